[design/circular_bezier_path_eval_macros.svh]
// Assertion helpers for the path evaluator.
// Each macro compiles away when SYNTHESIS is defined.
`ifndef CIRCULAR_BEZIER_PATH_EVAL_MACROS_SVH
`define CIRCULAR_BEZIER_PATH_EVAL_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define CBP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cbp check failed");
// Next-cycle implication under reset.
`define CBP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cbp check failed");
`else
`define CBP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CBP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[design/cbp_pkg.sv]
package cbp_pkg;

  localparam int PhaseBitsDef = 16;

  localparam int FracW  = 16;            // Q0.16 local parameter
  localparam int UW     = FracW + 1;     // 1 - f, may reach unity
  localparam int SqUW   = 2 * FracW + 1; // u^2
  localparam int SqFW   = 2 * FracW;     // f^2
  localparam int ProdW  = 3 * FracW + 1; // cubic terms, Q0.48
  localparam int WtFrac = 24;
  localparam int WtW    = WtFrac + 1;    // Q0.24 weights, unity included

  localparam int RegW   = 16;
  localparam int PosW   = 18;
  localparam int KcW    = 2 * RegW;

  localparam int AccFrac = 40;
  localparam int AccW    = 60;

  localparam logic [RegW-1:0] HandleK   = 16'd36195;
  localparam logic [RegW-1:0] RadiusRst = 16'd512;
  localparam logic [RegW-1:0] HeightRst = 16'd205;

  typedef enum logic {
    CfgRadius = 1'b0,
    CfgHeight = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SegQ0 = 2'd0,
    SegQ1 = 2'd1,
    SegQ2 = 2'd2,
    SegQ3 = 2'd3
  } seg_e;

  typedef struct packed {
    logic [FracW-1:0] f;
    logic [UW-1:0]    u;
    seg_e             seg;
  } phase_t;

  typedef struct packed {
    logic [WtW-1:0] w0;
    logic [WtW-1:0] w1;
    logic [WtW-1:0] w2;
    logic [WtW-1:0] w3;
    seg_e           seg;
  } wt_t;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [PosW-1:0] z;
    seg_e            seg;
  } res_t;

endpackage

[design/cbp_phase.sv]
module cbp_phase #(
  parameter int PHASE_BITS = cbp_pkg::PhaseBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output logic                  valid_o,
  output cbp_pkg::phase_t       word_o
);
  import cbp_pkg::*;

  localparam int LocBits = PHASE_BITS - 2;
  localparam int ShL     = (LocBits < FracW) ? FracW - LocBits : 0;
  localparam int ShR     = (LocBits > FracW) ? LocBits - FracW : 0;
  localparam int ExtW    = LocBits + ShL;

  logic [LocBits-1:0] loc;
  logic [ExtW-1:0]    ext;
  logic [FracW-1:0]   frac;
  phase_t             word_d, word_q;
  logic               valid_q;

  assign loc  = phase_i[LocBits-1:0];
  // bring the local parameter to Q0.16: widen, then truncate surplus bits
  assign ext  = ExtW'(loc) << ShL;
  assign frac = FracW'(ext >> ShR);

  always_comb begin
    word_d.seg = seg_e'(phase_i[PHASE_BITS-1 -: 2]);
    word_d.f   = frac;
    word_d.u   = (UW'(1) << FracW) - UW'(frac);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[design/cbp_bernstein.sv]
module cbp_bernstein (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cbp_pkg::phase_t word_i,
  output logic            valid_o,
  output cbp_pkg::wt_t    word_o
);
  import cbp_pkg::*;

  localparam int TriW = ProdW + 2;

  // squares
  logic [SqUW-1:0]  uu_q;
  logic [SqFW-1:0]  ff_q;
  logic [UW-1:0]    u2_q;
  logic [FracW-1:0] f2_q;
  seg_e             seg2_q;
  logic             v2_q;

  // cubes
  logic [ProdW-1:0] t0_q, t1_q, t2_q, t3_q;
  seg_e             seg3_q;
  logic             v3_q;

  // rounded weights
  logic [TriW-1:0]  t1x3, t2x3;
  logic [TriW-1:0]  half;
  wt_t              wt_d, wt_q;
  logic             v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= valid_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uu_q   <= SqUW'(word_i.u) * SqUW'(word_i.u);
      ff_q   <= SqFW'(word_i.f) * SqFW'(word_i.f);
      u2_q   <= word_i.u;
      f2_q   <= word_i.f;
      seg2_q <= word_i.seg;

      t0_q   <= ProdW'(uu_q) * ProdW'(u2_q);
      t1_q   <= ProdW'(uu_q) * ProdW'(f2_q);
      t2_q   <= ProdW'(ff_q) * ProdW'(u2_q);
      t3_q   <= ProdW'(ff_q) * ProdW'(f2_q);
      seg3_q <= seg2_q;

      wt_q   <= wt_d;
    end
  end

  assign half = TriW'(1) << (WtFrac - 1);
  assign t1x3 = (TriW'(t1_q) << 1) + TriW'(t1_q);
  assign t2x3 = (TriW'(t2_q) << 1) + TriW'(t2_q);

  // round half up from Q0.48 to Q0.24
  always_comb begin
    wt_d.w0  = WtW'((TriW'(t0_q) + half) >> WtFrac);
    wt_d.w1  = WtW'((t1x3 + half) >> WtFrac);
    wt_d.w2  = WtW'((t2x3 + half) >> WtFrac);
    wt_d.w3  = WtW'((TriW'(t3_q) + half) >> WtFrac);
    wt_d.seg = seg3_q;
  end

  assign valid_o = v4_q;
  assign word_o  = wt_q;

endmodule

[design/cbp_blend.sv]
module cbp_blend (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [cbp_pkg::RegW-1:0] radius_i,
  input  logic [cbp_pkg::RegW-1:0] height_i,
  input  logic                     valid_i,
  input  cbp_pkg::wt_t             word_i,
  output logic                     valid_o,
  output cbp_pkg::res_t            res_o
);
  import cbp_pkg::*;

  localparam int SumW  = WtW + 1;
  localparam int MulRW = RegW + SumW;
  localparam int MulKW = KcW + WtW;
  localparam int MagW  = AccW - AccFrac;
  localparam logic [MagW-1:0] MagMax = MagW'((64'd1 << (PosW - 1)) - 64'd1);

  logic [KcW-1:0]   kc_q;
  logic [SumW-1:0]  sa, sb;
  logic [MulRW-1:0] pa_q, pb_q;
  logic [MulKW-1:0] pk_q, qk_q;
  seg_e             seg5_q;
  logic             v5_q;

  logic [AccW-1:0]  acc_a, acc_b, rnd;
  logic [MagW-1:0]  mag_a, mag_b, sat_a, sat_b;
  logic [PosW-1:0]  a_p, b_p;
  res_t             res_d, res_q;
  logic             v6_q;

  // handle term radius * k, tracks the register
  always_ff @(posedge clk_i) begin
    kc_q <= KcW'(radius_i) * KcW'(HandleK);
  end

  assign sa = SumW'(word_i.w0) + SumW'(word_i.w1);
  assign sb = SumW'(word_i.w2) + SumW'(word_i.w3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= MulRW'(radius_i) * MulRW'(sa);
      pb_q   <= MulRW'(radius_i) * MulRW'(sb);
      pk_q   <= MulKW'(kc_q) * MulKW'(word_i.w2);
      qk_q   <= MulKW'(kc_q) * MulKW'(word_i.w1);
      seg5_q <= word_i.seg;
      res_q  <= res_d;
    end
  end

  // along and across terms, rounded half up to Q.8
  assign rnd   = AccW'(1) << (AccFrac - 1);
  assign acc_a = (AccW'(pa_q) << FracW) + AccW'(pk_q) + rnd;
  assign acc_b = (AccW'(pb_q) << FracW) + AccW'(qk_q) + rnd;
  assign mag_a = acc_a[AccW-1:AccFrac];
  assign mag_b = acc_b[AccW-1:AccFrac];
  assign sat_a = (mag_a > MagMax) ? MagMax : mag_a;
  assign sat_b = (mag_b > MagMax) ? MagMax : mag_b;
  assign a_p   = PosW'(sat_a);
  assign b_p   = PosW'(sat_b);

  // rotate the local frame into the quadrant
  always_comb begin
    res_d.seg = seg5_q;
    res_d.y   = {{(PosW - RegW){height_i[RegW-1]}}, height_i};
    unique case (seg5_q)
      SegQ0: begin
        res_d.x = a_p;
        res_d.z = -b_p;
      end
      SegQ1: begin
        res_d.x = -b_p;
        res_d.z = -a_p;
      end
      SegQ2: begin
        res_d.x = -a_p;
        res_d.z = b_p;
      end
      SegQ3: begin
        res_d.x = b_p;
        res_d.z = a_p;
      end
      default: begin
        res_d.x = '0;
        res_d.z = '0;
      end
    endcase
  end

  assign valid_o = v6_q;
  assign res_o   = res_q;

endmodule

[design/circular_bezier_path_eval.sv]
// Closed-loop path point evaluator. Each phase word (Q0.PHASE_BITS fraction of
// the loop) yields one point on a horizontal loop of four cubic Bezier quarter
// circles: pos_x and pos_z in signed Q9.8, pos_y the configured height, and the
// quarter that was used. One word is taken every clock cycle unless in_stall_o
// is high; its result passes through six register stages: phase split, the
// two multiplier stages that build the cubic weights, weight rounding, the
// radius products, and the final sum, rounding and rotation. A stall on the
// output holds the whole pipeline. Radius (register 0, unsigned Q8.8, reset
// 2.0) and height (register 1, signed Q8.8, reset about 0.8) are to be written
// only while no word is in flight; the block itself does not enforce this.
`include "circular_bezier_path_eval_macros.svh"

module circular_bezier_path_eval #(
  parameter int PHASE_BITS = cbp_pkg::PhaseBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [cbp_pkg::RegW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [PHASE_BITS-1:0]    phase_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [cbp_pkg::PosW-1:0] pos_x_o,
  output logic [cbp_pkg::PosW-1:0] pos_y_o,
  output logic [cbp_pkg::PosW-1:0] pos_z_o,
  output logic [1:0]               segment_o
);
  import cbp_pkg::*;

  logic [RegW-1:0] radius_q, height_q;
  logic [PosW-1:0] height_ext;
  logic            adv;
  logic            v_ph, v_wt;
  phase_t          ph_word;
  wt_t             wt_word;
  res_t            res;
  logic            x_ge, x_le, z_ge, z_le;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRadius: radius_q <= cfg_wdata_i;
        CfgHeight: height_q <= cfg_wdata_i;
        default:   radius_q <= radius_q;
      endcase
    end
  end

  // advance unless a finished word is held at the output
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  cbp_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .phase_i (phase_i),
    .valid_o (v_ph),
    .word_o  (ph_word)
  );

  cbp_bernstein u_bernstein (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_ph),
    .word_i  (ph_word),
    .valid_o (v_wt),
    .word_o  (wt_word)
  );

  cbp_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .radius_i (radius_q),
    .height_i (height_q),
    .valid_i  (v_wt),
    .word_i   (wt_word),
    .valid_o  (out_valid_o),
    .res_o    (res)
  );

  assign pos_x_o   = res.x;
  assign pos_y_o   = res.y;
  assign pos_z_o   = res.z;
  assign segment_o = res.seg;

  assign height_ext = {{(PosW - RegW){height_q[RegW-1]}}, height_q};

  // sign of each coordinate, zero counted on both sides
  assign x_ge = !pos_x_o[PosW-1];
  assign z_ge = !pos_z_o[PosW-1];
  assign x_le = pos_x_o[PosW-1] || (pos_x_o == '0);
  assign z_le = pos_z_o[PosW-1] || (pos_z_o == '0);

  `CBP_ASSERT_IMPL(a_height_pass, clk_i, rst_ni, out_valid_o, pos_y_o == height_ext)
  `CBP_ASSERT_IMPL(a_quad0_sign, clk_i, rst_ni, out_valid_o && res.seg == SegQ0, x_ge && z_le)
  `CBP_ASSERT_IMPL(a_quad1_sign, clk_i, rst_ni, out_valid_o && res.seg == SegQ1, x_le && z_le)
  `CBP_ASSERT_IMPL(a_quad2_sign, clk_i, rst_ni, out_valid_o && res.seg == SegQ2, x_le && z_ge)
  `CBP_ASSERT_IMPL(a_quad3_sign, clk_i, rst_ni, out_valid_o && res.seg == SegQ3, x_ge && z_ge)

endmodule

[bench/circular_bezier_path_eval_checker.sv]
`timescale 1ns / 1ps

module circular_bezier_path_eval_checker #(
  parameter int PHASE_BITS = cbp_pkg::PhaseBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [cbp_pkg::RegW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [PHASE_BITS-1:0]    phase_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [cbp_pkg::PosW-1:0] pos_x_i,
  input  logic [cbp_pkg::PosW-1:0] pos_y_i,
  input  logic [cbp_pkg::PosW-1:0] pos_z_i,
  input  logic [1:0]               segment_i,
  output int                       errors_o,
  output int                       pending_o
);
  import cbp_pkg::*;

  localparam int LocalBits = PHASE_BITS - 2;
  localparam int WtShift   = 3 * FracW - WtFrac;

  logic [RegW-1:0] radius_q;
  logic [RegW-1:0] height_q;
  res_t            points_q[$];

  function automatic longint unsigned round_half_up(longint unsigned v, int unsigned sh);
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [PosW-1:0] clip_coord(longint v);
    if (v > 131071) return PosW'(131071);
    if (v < -131072) return PosW'(-131072);
    return PosW'(v);
  endfunction

  // Evaluate the quarter-circle cubic for one phase word.
  function automatic res_t loop_point(logic [PHASE_BITS-1:0] ph, logic [RegW-1:0] rad,
                                      logic [RegW-1:0] hgt);
    longint unsigned loc, f, u, w0, w1, w2, w3, rr, kk, along, across;
    longint          a, b, x, z;
    seg_e            seg;
    res_t            pt;
    seg = seg_e'(ph[PHASE_BITS-1 -: 2]);
    loc = longint'(ph) & ((64'd1 << LocalBits) - 1);
    if (LocalBits >= FracW) f = loc >> (LocalBits - FracW);
    else f = loc << (FracW - LocalBits);
    u  = 64'd65536 - f;
    w0 = round_half_up(u * u * u, WtShift);
    w1 = round_half_up(64'd3 * u * u * f, WtShift);
    w2 = round_half_up(64'd3 * u * f * f, WtShift);
    w3 = round_half_up(f * f * f, WtShift);
    rr = longint'(rad) << 16;
    kk = longint'(rad) * longint'(HandleK);
    along  = round_half_up(rr * (w0 + w1) + kk * w2, AccFrac);
    across = round_half_up(kk * w1 + rr * (w2 + w3), AccFrac);
    a = longint'(along);
    b = longint'(across);
    case (seg)
      SegQ0: begin x = a;  z = -b; end
      SegQ1: begin x = -b; z = -a; end
      SegQ2: begin x = -a; z = b;  end
      default: begin x = b; z = a; end
    endcase
    pt.x   = clip_coord(x);
    pt.y   = {{(PosW-RegW){hgt[RegW-1]}}, hgt};
    pt.z   = clip_coord(z);
    pt.seg = seg;
    return pt;
  endfunction

  task automatic check_field(input string label, input logic [PosW-1:0] want,
                             input logic [PosW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, $signed(want), $signed(got));
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      radius_q  = RadiusRst;
      height_q  = HeightRst;
      errors_o  = 0;
      points_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (points_q.size() == 0) begin
          $display("%0t: unexpected word expected none actual x=%0d y=%0d z=%0d seg=%0d",
                   $time, $signed(pos_x_i), $signed(pos_y_i), $signed(pos_z_i), segment_i);
          errors_o++;
        end else begin
          want = points_q.pop_front();
          check_field("pos_x", want.x, pos_x_i);
          check_field("pos_y", want.y, pos_y_i);
          check_field("pos_z", want.z, pos_z_i);
          check_field("segment", want.seg, segment_i);
        end
      end
      // Predict with the registers in force before any write at this edge.
      if (in_valid_i && !in_stall_i)
        points_q.insert(points_q.size(), loop_point(phase_i, radius_q, height_q));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgRadius: radius_q = cfg_wdata_i;
          CfgHeight: height_q = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = points_q.size();
    end
  end

endmodule

[bench/circular_bezier_path_eval_test.sv]
`timescale 1ns / 1ps

module circular_bezier_path_eval_test;
  import cbp_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int LongHold   = 400;
  localparam int RandWords  = 150;
  localparam int Settings   = 8;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic                    cfg_idx_i   = 1'b0;
  logic [RegW-1:0]         cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic [PhaseBitsDef-1:0] phase_i     = '0;
  logic                    out_stall_i = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic [PosW-1:0]         pos_x_o;
  logic [PosW-1:0]         pos_y_o;
  logic [PosW-1:0]         pos_z_o;
  logic [1:0]              segment_o;

  int errors;
  int pending;
  int cycle_count = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  bit long_hold_req = 1'b0;

  logic [PhaseBitsDef-1:0] corner_phases[12] = '{
    16'h0000, 16'hFFFF, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000,
    16'hBFFF, 16'hC000, 16'h0001, 16'h2000, 16'hA000, 16'h5555
  };

  circular_bezier_path_eval dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .phase_i    (phase_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .segment_o  (segment_o)
  );

  circular_bezier_path_eval_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .phase_i    (phase_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .pos_x_i    (pos_x_o),
    .pos_y_i    (pos_y_o),
    .pos_z_i    (pos_z_o),
    .segment_i  (segment_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("circular_bezier_path_eval test failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_cycles();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [PhaseBitsDef-1:0] pick_phase();
    logic [1:0] quarter;
    quarter = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: return {quarter, 14'h0000};
      1: return {quarter, 14'h3FFF};
      default: return PhaseBitsDef'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else if (!quiet_rx && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (gap_cycles()) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_phase(input logic [PhaseBitsDef-1:0] ph);
    if (!quiet_tx && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_cycles()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    phase_i    <= ph;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drain the pipeline, then load radius and height on consecutive edges.
  task automatic load_loop(input logic [RegW-1:0] rad, input logic [RegW-1:0] hgt);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgRadius;
    cfg_wdata_i <= rad;
    @(posedge clk_i);
    cfg_idx_i   <= CfgHeight;
    cfg_wdata_i <= hgt;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [RegW-1:0] rad;
    logic [RegW-1:0] hgt;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values first, then the register extremes.
    foreach (corner_phases[i]) send_phase(corner_phases[i]);
    load_loop(16'hFFFF, 16'h8000);
    for (int i = 0; i < 6; i++) send_phase(corner_phases[i]);
    load_loop(16'h0000, 16'h7FFF);
    for (int i = 0; i < 6; i++) send_phase(corner_phases[i]);

    for (int s = 0; s < Settings; s++) begin
      case (s)
        0: begin rad = 16'hFFFF; hgt = 16'h7FFF; end
        1: begin rad = 16'h0000; hgt = 16'h8000; end
        default: begin
          if ($urandom_range(0, 3) == 0) rad = RegW'($urandom_range(1, 255));
          else rad = RegW'($urandom_range(0, 65535));
          hgt = RegW'($urandom_range(0, 65535));
        end
      endcase
      load_loop(rad, hgt);
      quiet_tx = (s == 2 || s == 4);
      quiet_rx = (s == 2);
      // Hold the output long enough to back the pipeline up to the input.
      if (s == 4) long_hold_req = 1'b1;
      for (int i = 0; i < RandWords; i++) send_phase(pick_phase());
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("circular_bezier_path_eval test passed");
    end else begin
      $display("circular_bezier_path_eval test failed");
    end
    $finish;
  end

endmodule

[circular_bezier_path_eval.f]
+incdir+design
design/cbp_pkg.sv
design/cbp_phase.sv
design/cbp_bernstein.sv
design/cbp_blend.sv
design/circular_bezier_path_eval.sv
bench/circular_bezier_path_eval_checker.sv
bench/circular_bezier_path_eval_test.sv
